FILE: hdl/plm_pkg.sv
// Shared types and constants for the probe loss and latency monitor.
`timescale 1ns / 1ps
`default_nettype none

package plm_pkg;

	// Item operation codes.
	localparam logic OP_SEND = 1'b0;
	localparam logic OP_RECV = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_SENT    = 2'd0,
		ST_MATCH   = 2'd1,
		ST_UNKNOWN = 2'd2,
		ST_FOREIGN = 2'd3
	} status_t;

	// Configuration register indexes (byte address is four times the index).
	localparam logic REG_FIRST_CODE     = 1'b0;
	localparam logic REG_INFLIGHT_LIMIT = 1'b1;

	// Register reset values.
	localparam logic [7:0] FIRST_CODE_RST     = 8'd0;
	localparam logic [6:0] INFLIGHT_LIMIT_RST = 7'd3;

endpackage

`default_nettype wire

FILE: hdl/probe_loss_latency_monitor.sv
// Probe loss and latency monitor: top level with stamp table and window tracking.
// Throughput: one item per cycle unless out_stall holds the result; the input register
// and the result register are each one stage, and the stamp table has one write and one
// registered read port per cycle. Reset (arst_n low) clears all counters, the pending
// window, the valid flags and the configuration registers at once; the data registers
// and the stamp table are not cleared; only stamps of pending slots are ever used.
`timescale 1ns / 1ps
`default_nettype none

module probe_loss_latency_monitor
	import plm_pkg::*;
#(
	parameter int NUM_CODES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [31:0] now,
	// Result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [7:0]       sent_code,
	output logic [31:0]      round_trip,
	output logic [31:0]      sent_count,
	output logic [31:0]      received_count,
	output logic [31:0]      lost_count,
	output logic [47:0]      rtt_total,
	output logic             reachable,
	// Configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int CW = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;
	localparam int PW = $clog2(NUM_CODES + 1);
	localparam logic [7:0]  NC8  = 8'(NUM_CODES);
	localparam logic [CW:0] NCW  = (CW + 1)'(NUM_CODES);
	localparam logic [PW-1:0] NCP = PW'(NUM_CODES);
	localparam logic [CW-1:0] LAST_IDX = CW'(NUM_CODES - 1);

	// Step an index round the cyclic window.
	function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] v);
		logic [CW-1:0] r;
		if (v == LAST_IDX) begin
			r = '0;
		end else begin
			r = v + CW'(1);
		end
		return r;
	endfunction

	// Configuration registers.
	logic [7:0] first_code_q;
	logic [6:0] inflight_limit_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_code_q     <= FIRST_CODE_RST;
			inflight_limit_q <= INFLIGHT_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FIRST_CODE:     first_code_q     <= pwdata[7:0];
				REG_INFLIGHT_LIMIT: inflight_limit_q <= pwdata[6:0];
				default:            first_code_q     <= first_code_q;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[2])
			REG_FIRST_CODE:     prdata = {24'd0, first_code_q};
			REG_INFLIGHT_LIMIT: prdata = {25'd0, inflight_limit_q};
			default:            prdata = '0;
		endcase
	end

	// Handshake: the input register moves on when the result register is free.
	logic s1_valid_q;
	logic out_valid_q;
	logic fire;
	logic accept;

	assign fire     = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && !fire;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (fire) begin
				s1_valid_q <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Input register.
	logic        op_s1;
	logic [7:0]  rx_s1;
	logic [31:0] now_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op;
			rx_s1  <= rx_byte;
			now_s1 <= now;
		end
	end

	// Window state.
	logic [CW-1:0] oldest_q;
	logic [CW-1:0] next_q;
	logic [PW-1:0] pending_q;
	logic [31:0]   sent_q;
	logic [31:0]   recv_q;
	logic [31:0]   lost_q;
	logic [31:0]   inflight_q;
	logic [47:0]   rtt_sum_q;
	logic          reach_q;

	// Stamp table read for the incoming beat, with bypass of a same-slot write.
	logic [7:0]    in_offset;
	logic          in_rd;
	logic [CW-1:0] rd_addr;
	logic          wr_en;
	logic [31:0]   stamp_mem [NUM_CODES];
	logic [31:0]   stamp_s1;
	logic          fwd_s1;
	logic [31:0]   fwd_now_s1;

	assign in_offset = rx_byte - first_code_q;
	assign in_rd     = accept && (op == OP_RECV) && (in_offset < NC8);
	assign rd_addr   = in_offset[CW-1:0];
	assign wr_en     = fire && (op_s1 == OP_SEND);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stamp_mem[next_q] <= now_s1;
		end
		if (in_rd) begin
			stamp_s1   <= stamp_mem[rd_addr];
			fwd_s1     <= wr_en && (next_q == rd_addr);
			fwd_now_s1 <= now_s1;
		end
	end

	// Decode of the item in the input register.
	logic [7:0]    offset;
	logic [CW-1:0] offset_idx;
	logic          in_range;
	logic [CW:0]   dist_w;
	logic [CW-1:0] gap;
	logic          pending_hit;
	logic [31:0]   stamp;
	logic [31:0]   rtt;
	logic [31:0]   inflight_inc;
	status_t       st;

	assign offset     = rx_s1 - first_code_q;
	assign offset_idx = offset[CW-1:0];
	assign in_range   = offset < NC8;

	always_comb begin
		if (offset_idx >= oldest_q) begin
			dist_w = {1'b0, offset_idx} - {1'b0, oldest_q};
		end else begin
			dist_w = {1'b0, offset_idx} + NCW - {1'b0, oldest_q};
		end
	end

	assign gap          = dist_w[CW-1:0];
	assign pending_hit  = PW'(gap) < pending_q;
	assign stamp        = fwd_s1 ? fwd_now_s1 : stamp_s1;
	assign rtt          = now_s1 - stamp;
	assign inflight_inc = inflight_q + 32'd1;

	always_comb begin
		priority if (op_s1 == OP_SEND) begin
			st = ST_SENT;
		end else if (!in_range) begin
			st = ST_FOREIGN;
		end else if (!pending_hit) begin
			st = ST_UNKNOWN;
		end else begin
			st = ST_MATCH;
		end
	end

	// State update, one item per fire.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q   <= '0;
			next_q     <= '0;
			pending_q  <= '0;
			sent_q     <= '0;
			recv_q     <= '0;
			lost_q     <= '0;
			inflight_q <= '0;
			rtt_sum_q  <= '0;
			reach_q    <= 1'b0;
		end else if (fire) begin
			unique case (st)
				ST_SENT: begin
					next_q <= wrap_inc(next_q);
					if (pending_q == NCP) begin
						oldest_q <= wrap_inc(oldest_q);
					end else begin
						pending_q <= pending_q + PW'(1);
					end
					sent_q     <= sent_q + 32'd1;
					inflight_q <= inflight_inc;
					reach_q    <= inflight_inc <= {25'd0, inflight_limit_q};
				end
				ST_MATCH: begin
					rtt_sum_q  <= rtt_sum_q + {16'd0, rtt};
					recv_q     <= recv_q + 32'd1;
					lost_q     <= lost_q + 32'(gap);
					oldest_q   <= wrap_inc(offset_idx);
					pending_q  <= pending_q - PW'(gap) - PW'(1);
					inflight_q <= inflight_q - 32'(gap) - 32'd1;
				end
				default: begin
					reach_q <= reach_q;
				end
			endcase
		end
	end

	// Result register; the totals are read straight from the state.
	status_t     status_q;
	logic [7:0]  code_q;
	logic [31:0] rtt_q;

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= st;
			code_q   <= (st == ST_SENT) ? first_code_q + 8'(next_q) : 8'd0;
			rtt_q    <= (st == ST_MATCH) ? rtt : 32'd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign sent_code      = code_q;
	assign round_trip     = rtt_q;
	assign sent_count     = sent_q;
	assign received_count = recv_q;
	assign lost_count     = lost_q;
	assign rtt_total      = rtt_sum_q;
	assign reachable      = reach_q;

endmodule

`default_nettype wire

FILE: hdl/plm_checker.sv
// Port-level checks for the probe loss and latency monitor, with their bind.
`timescale 1ns / 1ps
`default_nettype none

module plm_checker
	import plm_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  status,
	input wire logic [7:0]  sent_code,
	input wire logic [31:0] round_trip,
	input wire logic [31:0] sent_count,
	input wire logic [31:0] lost_count,
	input wire logic [47:0] rtt_total
);

	// A stalled result beat holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(round_trip)
			&& $stable(sent_code))
		else $error("result beat changed while stalled");

	// The send total only moves together with a freshly shown send result.
	a_sent_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(sent_count) |-> out_valid && (status == ST_SENT))
		else $error("send total moved without a send result");

	// Loss and latency totals only move with a matched probe.
	a_match_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(!$stable(lost_count) || !$stable(rtt_total)) |-> out_valid && (status == ST_MATCH))
		else $error("loss or latency total moved without a matched probe");

	// Code and round trip are zero outside their own status.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ST_SENT) || (sent_code == 8'd0))
			&& ((status == ST_MATCH) || (round_trip == 32'd0)))
		else $error("code or round trip not zero for this status");

endmodule

bind probe_loss_latency_monitor plm_checker u_plm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.sent_code  (sent_code),
	.round_trip (round_trip),
	.sent_count (sent_count),
	.lost_count (lost_count),
	.rtt_total  (rtt_total)
);

`default_nettype wire

FILE: bench/probe_loss_latency_monitor_tb.sv
// Self-checking testbench for the probe loss and latency monitor.
`timescale 1ns / 1ps

module probe_loss_latency_monitor_tb;
	import plm_pkg::*;

	localparam int NUM_CODES = 64;
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES = 300;

	// One input beat as queued for the driver.
	typedef struct {
		logic        op;
		logic [7:0]  rx;
		logic [31:0] tick;
	} probe_beat_t;

	// One result beat as predicted.
	typedef struct packed {
		status_t     status;
		logic [7:0]  code;
		logic [31:0] rtt;
		logic [31:0] sent;
		logic [31:0] rcvd;
		logic [31:0] lost;
		logic [47:0] rtt_sum;
		logic        reach;
	} probe_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = 1'b0;
	logic [7:0]  rx_byte = 8'd0;
	logic [31:0] now = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [7:0]  sent_code;
	logic [31:0] round_trip;
	logic [31:0] sent_count;
	logic [31:0] received_count;
	logic [31:0] lost_count;
	logic [47:0] rtt_total;
	logic        reachable;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	probe_loss_latency_monitor #(.NUM_CODES(NUM_CODES)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .rx_byte(rx_byte), .now(now),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .sent_code(sent_code), .round_trip(round_trip),
		.sent_count(sent_count), .received_count(received_count),
		.lost_count(lost_count), .rtt_total(rtt_total), .reachable(reachable),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Clock generation.
	initial begin
		forever #5 clk = ~clk;
	end

	probe_beat_t   beat_queue[$];
	probe_result_t pending_results[$];
	int            mismatches = 0;
	int            hold_seq = 0;

	// Mirror of the configuration registers.
	logic [7:0] cfg_first_code = FIRST_CODE_RST;
	logic [6:0] cfg_limit = INFLIGHT_LIMIT_RST;

	// Predicted block state.
	logic [31:0] stamp_tbl [NUM_CODES];
	int unsigned head_slot = 0;
	int unsigned tail_slot = 0;
	int unsigned window_fill = 0;
	logic [31:0] sent_tot = '0;
	logic [31:0] recv_tot = '0;
	logic [31:0] lost_tot = '0;
	logic [47:0] rtt_acc = '0;
	logic        reach_now = 1'b0;

	// Shadow of the pending window used only to shape the stimulus.
	int unsigned gen_next = 0;
	int unsigned gen_oldest = 0;
	int unsigned gen_pend = 0;
	logic [31:0] gen_tick = 32'd0;

	// Advance the predicted state by one accepted beat and return its result.
	function automatic probe_result_t track_probe_beat(logic op_i, logic [7:0] rx_i,
			logic [31:0] now_i);
		probe_result_t r;
		logic [7:0]    offs;
		int unsigned   gap;
		logic [31:0]   rtt;
		logic [31:0]   inflight;
		r = '0;
		if (op_i == OP_SEND) begin
			r.code = cfg_first_code + 8'(tail_slot);
			stamp_tbl[tail_slot] = now_i;
			tail_slot = (tail_slot + 1) % NUM_CODES;
			// A full window drops its oldest code silently.
			if (window_fill >= NUM_CODES)
				head_slot = (head_slot + 1) % NUM_CODES;
			else
				window_fill++;
			sent_tot = sent_tot + 32'd1;
			inflight = sent_tot - recv_tot - lost_tot;
			reach_now = (inflight <= 32'(cfg_limit));
			r.status = ST_SENT;
		end else begin
			offs = rx_i - cfg_first_code;
			if (offs >= NUM_CODES) begin
				r.status = ST_FOREIGN;
			end else begin
				gap = (offs + NUM_CODES - head_slot) % NUM_CODES;
				if (gap >= window_fill) begin
					r.status = ST_UNKNOWN;
				end else begin
					// Match: every older pending code is counted lost.
					rtt = now_i - stamp_tbl[offs];
					r.rtt = rtt;
					rtt_acc = rtt_acc + {16'd0, rtt};
					recv_tot = recv_tot + 32'd1;
					lost_tot = lost_tot + 32'(gap);
					head_slot = (offs + 1) % NUM_CODES;
					window_fill = window_fill - (gap + 1);
					r.status = ST_MATCH;
				end
			end
		end
		r.sent = sent_tot;
		r.rcvd = recv_tot;
		r.lost = lost_tot;
		r.rtt_sum = rtt_acc;
		r.reach = reach_now;
		return r;
	endfunction

	// Queue a beat and keep the stimulus window shadow in step.
	task automatic push_beat(logic op_i, logic [7:0] rx_i, logic [31:0] tick_i);
		probe_beat_t b;
		logic [7:0]  offs;
		int unsigned gap;
		b.op = op_i;
		b.rx = rx_i;
		b.tick = tick_i;
		beat_queue.push_back(b);
		if (op_i == OP_SEND) begin
			gen_next = (gen_next + 1) % NUM_CODES;
			if (gen_pend >= NUM_CODES)
				gen_oldest = (gen_oldest + 1) % NUM_CODES;
			else
				gen_pend++;
		end else begin
			offs = rx_i - cfg_first_code;
			if (offs < NUM_CODES) begin
				gap = (offs + NUM_CODES - gen_oldest) % NUM_CODES;
				if (gap < gen_pend) begin
					gen_oldest = (offs + 1) % NUM_CODES;
					gen_pend = gen_pend - (gap + 1);
				end
			end
		end
	endtask

	// Tick time mostly creeps forward, with the odd jump anywhere.
	function automatic logic [31:0] next_tick();
		if ($urandom_range(0, 15) == 0)
			gen_tick = $urandom;
		else
			gen_tick = gen_tick + $urandom_range(0, 50);
		return gen_tick;
	endfunction

	// Random beats: sends, matching receipts, stale codes and foreign bytes.
	task automatic random_phase(int count, int send_pct);
		int          pick;
		int unsigned slot;
		logic [7:0]  b;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < send_pct) begin
				push_beat(OP_SEND, 8'($urandom), next_tick());
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 7 && gen_pend > 0) begin
					slot = ($urandom_range(0, 2) == 0) ? $urandom_range(0, gen_pend - 1) : 0;
					b = cfg_first_code + 8'((gen_oldest + slot) % NUM_CODES);
				end else if (pick < 8 && gen_pend < NUM_CODES) begin
					slot = gen_oldest + gen_pend + $urandom_range(0, NUM_CODES - gen_pend - 1);
					b = cfg_first_code + 8'(slot % NUM_CODES);
				end else if (pick < 9) begin
					b = cfg_first_code + 8'(NUM_CODES + $urandom_range(0, 255 - NUM_CODES));
				end else begin
					b = 8'($urandom);
				end
				push_beat(OP_RECV, b, next_tick());
			end
		end
	endtask

	// Read a register back and compare it with the mirror.
	task automatic check_reg(logic idx);
		logic [31:0] want;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		want = (idx == REG_FIRST_CODE) ? {24'd0, cfg_first_code} : {25'd0, cfg_limit};
		if (prdata !== want) begin
			$error("prdata at %0d: expected %0h, got %0h", {idx, 2'b00}, want, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write a register with junk above its width, then read it back.
	task automatic write_reg(logic idx, logic [31:0] value);
		logic [31:0] wdata;
		wdata = value | ($urandom & ((idx == REG_FIRST_CODE) ? 32'hFFFF_FF00 : 32'hFFFF_FF80));
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_FIRST_CODE)
			cfg_first_code = wdata[7:0];
		else
			cfg_limit = wdata[6:0];
		check_reg(idx);
	endtask

	// Wait until every queued beat has gone through and every result is back.
	task automatic wait_idle();
		while (beat_queue.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(string name, logic [47:0] want_v, logic [47:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			mismatches++;
		end
	endtask

	// Driver: offers queued beats in bursts with random gaps between them.
	always @(posedge clk) begin : drive_probes
		probe_beat_t b;
		int          burst_left;
		int          gap_left;
		if (arst_n) begin
			if (in_valid && !in_stall)
				pending_results.push_back(track_probe_beat(op, rx_byte, now));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (beat_queue.size() > 0) begin
					b = beat_queue.pop_front();
					in_valid <= 1'b1;
					op <= b.op;
					rx_byte <= b.rx;
					now <= b.tick;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result beat and stalls on a pattern of its own.
	always @(posedge clk) begin : check_results
		probe_result_t want;
		int            hold_seen;
		int            hold_left;
		int            stall_mode;
		int            stretch_left;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result beat with nothing expected");
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", want.status, status);
					check_field("sent_code", want.code, sent_code);
					check_field("round_trip", want.rtt, round_trip);
					check_field("sent_count", want.sent, sent_count);
					check_field("received_count", want.rcvd, received_count);
					check_field("lost_count", want.lost, lost_count);
					check_field("rtt_total", want.rtt_sum, rtt_total);
					check_field("reachable", want.reach, reachable);
				end
			end
			// A requested hold-off overrides the normal stall pattern.
			if (hold_seen != hold_seq) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (stretch_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stretch_left = $urandom_range(10, 60);
			end else begin
				stretch_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 2) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Watchdog on the whole run.
	initial begin : watchdog
		int cycle_cnt;
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Test sequence.
	initial begin : run_test
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_reg(REG_FIRST_CODE);
		check_reg(REG_INFLIGHT_LIMIT);

		// Directed beats with reset settings: empty window, foreign bytes,
		// tick wrap, loss of older codes, stale and never-sent codes.
		push_beat(OP_RECV, 8'd0, 32'd0);
		push_beat(OP_RECV, 8'd255, 32'hFFFF_FFFF);
		push_beat(OP_SEND, 8'hFF, 32'hFFFF_FFF0);
		push_beat(OP_SEND, 8'h00, 32'hFFFF_FFFF);
		push_beat(OP_SEND, 8'hA5, 32'd0);
		push_beat(OP_SEND, 8'h5A, 32'd5);
		push_beat(OP_RECV, 8'd1, 32'h10);
		push_beat(OP_RECV, 8'd1, 32'h11);
		push_beat(OP_RECV, 8'd0, 32'h12);
		push_beat(OP_RECV, 8'd63, 32'h13);
		push_beat(OP_RECV, 8'd64, 32'h14);
		push_beat(OP_RECV, 8'd3, 32'hFFFF_FFFF);
		push_beat(OP_SEND, 8'h0F, 32'd0);
		push_beat(OP_SEND, 8'hF0, 32'd7);
		push_beat(OP_RECV, 8'd5, 32'd20);
		gen_tick = 32'hFFFF_FF00;
		wait_idle();

		// High base and zero limit.
		write_reg(REG_FIRST_CODE, 32'd192);
		write_reg(REG_INFLIGHT_LIMIT, 32'd0);
		random_phase(100, 50);
		wait_idle();

		// Base at the top so codes wrap; long hold-off while the window overflows.
		write_reg(REG_FIRST_CODE, 32'd255);
		write_reg(REG_INFLIGHT_LIMIT, 32'd64);
		hold_seq++;
		random_phase(70, 100);
		random_phase(130, 45);
		wait_idle();

		// Random base with the widest limit.
		write_reg(REG_FIRST_CODE, 32'($urandom_range(0, 255)));
		write_reg(REG_INFLIGHT_LIMIT, 32'd127);
		random_phase(100, 55);
		wait_idle();

		// Base back to zero with a random limit.
		write_reg(REG_FIRST_CODE, 32'd0);
		write_reg(REG_INFLIGHT_LIMIT, 32'($urandom_range(0, 127)));
		random_phase(100, 50);
		wait_idle();

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: sim.f
hdl/plm_pkg.sv
hdl/probe_loss_latency_monitor.sv
hdl/plm_checker.sv
bench/probe_loss_latency_monitor_tb.sv
